/* sv/ibd_pkg.sv */
package ibd_pkg;

	localparam int PIX_W     = 8;
	localparam int NUM_CH    = 3;
	localparam int DIM_W     = 13;
	localparam int DIM_MAX   = 4096;
	localparam int CNT_W     = 12;
	localparam int BC_W      = 13;
	localparam int FREG_W    = 5;
	localparam int DIV_STEPS = 8;
	localparam int STEP_W    = 3;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 4;

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [1:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_FACTOR,
		REG_METHOD
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic div_step;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic emit;
		logic box;
		logic out_free;
	} dp_status_t;

endpackage

/* sv/ibd_ifs.sv */
interface ibd_in_if;
	import ibd_pkg::*;

	logic valid;
	logic ready;
	pix_t in_red;
	pix_t in_green;
	pix_t in_blue;

	modport source(output valid, in_red, in_green, in_blue, input ready);
	modport sink(input valid, in_red, in_green, in_blue, output ready);
endinterface

interface ibd_out_if;
	import ibd_pkg::*;

	logic valid;
	logic ready;
	pix_t out_red;
	pix_t out_green;
	pix_t out_blue;
	logic frame_end;

	modport source(output valid, out_red, out_green, out_blue, frame_end, input ready);
	modport sink(input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

/* sv/ibd_cfg.sv */
module ibd_cfg #(
	parameter int MAX_FACTOR = 16,
	localparam int FW = $clog2(MAX_FACTOR + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ibd_pkg::ADDR_W-1:0]  paddr,
	input  logic [ibd_pkg::DATA_W-1:0]  pwdata,
	output logic [ibd_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output logic [ibd_pkg::DIM_W-1:0]   w,
	output logic [ibd_pkg::DIM_W-1:0]   h,
	output logic [FW-1:0]               f,
	output logic                        method,
	output logic                        restart
);
	import ibd_pkg::*;

	localparam logic [7:0] FMAX = 8'(MAX_FACTOR);

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [FREG_W-1:0] factor_q;
	logic              method_q;
	reg_idx_t          idx;
	logic              wr;
	logic [7:0]        fz;

	assign idx     = reg_idx_t'(paddr[3:2]);
	assign wr      = psel & penable & pwrite;
	assign restart = wr;
	assign pready  = 1'b1;
	assign method  = method_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(512);
			height_q <= DIM_W'(512);
			factor_q <= FREG_W'(2);
			method_q <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				REG_FACTOR: factor_q <= pwdata[FREG_W-1:0];
				REG_METHOD: method_q <= pwdata[0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:  prdata = {{(DATA_W-DIM_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(DATA_W-DIM_W){1'b0}}, height_q};
			REG_FACTOR: prdata = {{(DATA_W-FREG_W){1'b0}}, factor_q};
			REG_METHOD: prdata = {{(DATA_W-1){1'b0}}, method_q};
			default:    prdata = '0;
		endcase
	end

	// saturate to the legal ranges
	always_comb begin
		fz = {{(8-FREG_W){1'b0}}, factor_q};
		if (width_q == '0) begin
			w = DIM_W'(1);
		end else if (width_q > DIM_W'(DIM_MAX)) begin
			w = DIM_W'(DIM_MAX);
		end else begin
			w = width_q;
		end
		if (height_q == '0) begin
			h = DIM_W'(1);
		end else if (height_q > DIM_W'(DIM_MAX)) begin
			h = DIM_W'(DIM_MAX);
		end else begin
			h = height_q;
		end
		if (fz < 8'd2) begin
			f = FW'(2);
		end else if (fz > FMAX) begin
			f = FW'(MAX_FACTOR);
		end else begin
			f = FW'(fz);
		end
	end

endmodule

/* sv/ibd_ctrl.sv */
module ibd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output ibd_pkg::ctrl_cmd_t  cmd,
	input  ibd_pkg::dp_status_t status
);
	import ibd_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [STEP_W-1:0] step_q;
	logic              last_step;

	assign last_step = (step_q == STEP_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_UPD;
			end
			ST_UPD: begin
				if (!status.emit) state_d = ST_IDLE;
				else if (status.box) state_d = ST_DIV;
				else state_d = ST_LOAD;
			end
			ST_DIV: begin
				if (last_step) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_UPD:  cmd.update   = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_LOAD: cmd.load_out = status.out_free;
			default: ;
		endcase
	end

endmodule

/* sv/ibd_dp.sv */
module ibd_dp #(
	parameter int MAX_OUT_COLUMNS = 2048,
	parameter int MAX_FACTOR      = 16,
	localparam int FW = $clog2(MAX_FACTOR + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ibd_pkg::DIM_W-1:0]  w,
	input  logic [ibd_pkg::DIM_W-1:0]  h,
	input  logic [FW-1:0]              f,
	input  logic                       method,
	input  logic                       restart,
	input  ibd_pkg::ctrl_cmd_t         cmd,
	output ibd_pkg::dp_status_t        status,
	input  ibd_pkg::pix_t              in_red,
	input  ibd_pkg::pix_t              in_green,
	input  ibd_pkg::pix_t              in_blue,
	output logic                       out_valid,
	input  logic                       out_ready,
	output ibd_pkg::pix_t              out_red,
	output ibd_pkg::pix_t              out_green,
	output ibd_pkg::pix_t              out_blue,
	output logic                       frame_end
);
	import ibd_pkg::*;

	localparam int SW     = PIX_W + 2 * $clog2(MAX_FACTOR);
	localparam int MAW    = (MAX_OUT_COLUMNS > 1) ? $clog2(MAX_OUT_COLUMNS) : 1;
	localparam int AREA_W = 2 * FW;
	localparam int DW     = SW + PIX_W;

	// position counters
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [FW-1:0]    cib_q;
	logic [FW-1:0]    rib_q;
	logic [BC_W-1:0]  bc_q;
	logic [DIM_W-1:0] col_start_q;
	logic [DIM_W-1:0] row_start_q;

	logic [DIM_W:0] cs_f;
	logic [DIM_W:0] cs_2f;
	logic [DIM_W:0] rs_f;
	logic [DIM_W:0] rs_2f;
	logic           col_ok;
	logic           row_ok;
	logic           col_last;
	logic           row_last;
	logic           cib_last;
	logic           rib_last;
	logic           line_end;
	logic           frame_done;

	// per-word latches
	logic [NUM_CH-1:0][PIX_W-1:0] px_q;
	logic                         ok_q;
	logic                         tl_q;
	logic                         br_q;
	logic                         last_q;
	logic [MAW-1:0]               addr_q;

	// accumulator row
	logic [NUM_CH-1:0][SW-1:0] mem [MAX_OUT_COLUMNS];
	logic [NUM_CH-1:0][SW-1:0] rd_s1;
	logic [NUM_CH-1:0][SW-1:0] new_sum;

	// divider
	logic [NUM_CH-1:0][SW-1:0]    rem_q;
	logic [NUM_CH-1:0][PIX_W-1:0] quo_q;
	logic [DW-1:0]                dsr_q;
	logic [AREA_W-1:0]            area;
	logic [NUM_CH-1:0]            ge;
	logic [NUM_CH-1:0][SW-1:0]    rem_sub;

	// output register
	logic                         out_valid_q;
	logic [NUM_CH-1:0][PIX_W-1:0] out_pix_q;
	logic                         frame_end_q;

	assign cs_f   = {1'b0, col_start_q} + (DIM_W+1)'(f);
	assign cs_2f  = cs_f + (DIM_W+1)'(f);
	assign rs_f   = {1'b0, row_start_q} + (DIM_W+1)'(f);
	assign rs_2f  = rs_f + (DIM_W+1)'(f);

	assign col_ok   = (cs_f <= {1'b0, w}) &&
		({1'b0, bc_q} < (BC_W+1)'(MAX_OUT_COLUMNS));
	assign row_ok   = (rs_f <= {1'b0, h});
	assign col_last = (cs_2f > {1'b0, w}) ||
		({1'b0, bc_q} == (BC_W+1)'(MAX_OUT_COLUMNS - 1));
	assign row_last = (rs_2f > {1'b0, h});
	assign cib_last = (cib_q == f - FW'(1));
	assign rib_last = (rib_q == f - FW'(1));
	assign line_end   = ({1'b0, col_q} == w - DIM_W'(1));
	assign frame_done = ({1'b0, row_q} == h - DIM_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			cib_q       <= '0;
			rib_q       <= '0;
			bc_q        <= '0;
			col_start_q <= '0;
			row_start_q <= '0;
		end else if (restart) begin
			col_q       <= '0;
			row_q       <= '0;
			cib_q       <= '0;
			rib_q       <= '0;
			bc_q        <= '0;
			col_start_q <= '0;
			row_start_q <= '0;
		end else if (cmd.accept) begin
			if (line_end) begin
				col_q       <= '0;
				cib_q       <= '0;
				bc_q        <= '0;
				col_start_q <= '0;
				if (frame_done) begin
					row_q       <= '0;
					rib_q       <= '0;
					row_start_q <= '0;
				end else begin
					row_q <= row_q + CNT_W'(1);
					if (rib_last) begin
						rib_q       <= '0;
						row_start_q <= row_start_q + DIM_W'(f);
					end else begin
						rib_q <= rib_q + FW'(1);
					end
				end
			end else begin
				col_q <= col_q + CNT_W'(1);
				if (cib_last) begin
					cib_q       <= '0;
					bc_q        <= bc_q + BC_W'(1);
					col_start_q <= col_start_q + DIM_W'(f);
				end else begin
					cib_q <= cib_q + FW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q   <= {in_blue, in_green, in_red};
			ok_q   <= col_ok && row_ok;
			tl_q   <= (cib_q == '0) && (rib_q == '0);
			br_q   <= cib_last && rib_last;
			last_q <= col_last && row_last;
			addr_q <= bc_q[MAW-1:0];
			rd_s1  <= mem[bc_q[MAW-1:0]];
		end
		if (cmd.update && ok_q && !method) begin
			mem[addr_q] <= new_sum;
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			if (tl_q) new_sum[c] = SW'(px_q[c]);
			else new_sum[c] = rd_s1[c] + SW'(px_q[c]);
		end
	end

	assign status.emit     = ok_q && (method ? tl_q : br_q);
	assign status.box      = !method;
	assign status.out_free = !out_valid_q || out_ready;

	// restoring division by f*f, one quotient bit per step
	assign area = AREA_W'(f) * AREA_W'(f);

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			ge[c]      = ({{(DW-SW){1'b0}}, rem_q[c]} >= dsr_q);
			rem_sub[c] = rem_q[c] - dsr_q[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			rem_q <= new_sum;
			dsr_q <= DW'(area) << (DIV_STEPS - 1);
		end else if (cmd.div_step) begin
			for (int c = 0; c < NUM_CH; c++) begin
				if (ge[c]) rem_q[c] <= rem_sub[c];
				quo_q[c] <= {quo_q[c][PIX_W-2:0], ge[c]};
			end
			dsr_q <= dsr_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_pix_q   <= method ? px_q : quo_q;
			frame_end_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = out_pix_q[0];
	assign out_green = out_pix_q[1];
	assign out_blue  = out_pix_q[2];
	assign frame_end = frame_end_q;

endmodule

/* sv/image_block_downscale_unit.sv */
// channel    | dir | carries
// pixel_in   | in  | in_red, in_green, in_blue: raster-order input pixel
// pixel_out  | out | out_red, out_green, out_blue, frame_end: shrunk pixel
// apb (p*)   | in  | width, height, factor, method registers at 0x0..0xC
//
// One word in flight: each input pixel is accepted in IDLE and then takes
// UPD for the accumulator read-modify-write. A box-mode block emits after
// the restoring divider steps (DIV) and the output register load (LOAD);
// an undersample emit goes from UPD straight to the load.
// Reset restores the register defaults and clears all position counters.
// An emit that finds the output register full waits and holds off the input.
module image_block_downscale_unit #(
	parameter int MAX_OUT_COLUMNS = 2048,
	parameter int MAX_FACTOR      = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ibd_in_if.sink                      pixel_in,
	ibd_out_if.source                   pixel_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ibd_pkg::ADDR_W-1:0]  paddr,
	input  logic [ibd_pkg::DATA_W-1:0]  pwdata,
	output logic [ibd_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import ibd_pkg::*;

	localparam int FW = $clog2(MAX_FACTOR + 1);

	logic [DIM_W-1:0] w;
	logic [DIM_W-1:0] h;
	logic [FW-1:0]    f;
	logic             method;
	logic             restart;
	logic             in_ready;
	ctrl_cmd_t        cmd;
	dp_status_t       status;

	ibd_cfg #(
		.MAX_FACTOR(MAX_FACTOR)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.w      (w),
		.h      (h),
		.f      (f),
		.method (method),
		.restart(restart)
	);

	ibd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(pixel_in.valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.status  (status)
	);

	assign pixel_in.ready = in_ready;

	ibd_dp #(
		.MAX_OUT_COLUMNS(MAX_OUT_COLUMNS),
		.MAX_FACTOR     (MAX_FACTOR)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.w        (w),
		.h        (h),
		.f        (f),
		.method   (method),
		.restart  (restart),
		.cmd      (cmd),
		.status   (status),
		.in_red   (pixel_in.in_red),
		.in_green (pixel_in.in_green),
		.in_blue  (pixel_in.in_blue),
		.out_valid(pixel_out.valid),
		.out_ready(pixel_out.ready),
		.out_red  (pixel_out.out_red),
		.out_green(pixel_out.out_green),
		.out_blue (pixel_out.out_blue),
		.frame_end(pixel_out.frame_end)
	);

endmodule
